@@ rtl/core/cltok_pkg.sv @@
// Shared types and constants of the command line tokenizer.
`default_nettype none

package cltok_pkg;

    // Character codes
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_PIPE    = 8'h7C;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;

    // Counter width and saturation limit
    localparam int unsigned CNT_W = 12;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_TRIM_PIPE   = 3'd1;
    localparam logic [2:0] ST_EXTRA_BRACE = 3'd2;
    localparam logic [2:0] ST_EXTRA_PAREN = 3'd3;
    localparam logic [2:0] ST_UNCLOSED    = 3'd4;

    // Early error codes, held until line end
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_BRACE = 2'd2;
    localparam logic [1:0] ERR_PAREN = 2'd3;

    // Open mask bit positions
    localparam int unsigned OM_QUOTE = 0;
    localparam int unsigned OM_BRACE = 1;
    localparam int unsigned OM_PAREN = 2;
    localparam int unsigned OM_PIPE  = 3;

    // One result word
    typedef struct packed {
        logic             char_valid;
        logic [7:0]       out_char;
        logic             token_start;
        logic             is_status;
        logic [2:0]       status_code;
        logic [3:0]       open_mask;
        logic [CNT_W-1:0] token_count;
        logic             last;
    } t_result;

    // Comment stage verdict handed to the splitter
    typedef struct packed {
        logic keep;
        logic trim_pipe;
    } t_trim;

    // Results of one step: byte word and status word
    typedef struct packed {
        logic    byte_valid;
        t_result byte_res;
        logic    stat_valid;
        t_result stat_res;
    } t_step_res;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/command_line_tokenizer_top.sv @@
// Top level of the command line tokenizer.
`default_nettype none

// Takes a command line one byte per word, strips '#' comments (a backslash
// shields the next byte, a '|' region hides '#'), and splits what remains
// into tokens at whitespace outside quotes, pipes, braces and parentheses.
// Each kept token byte comes out as one word with a token-start flag; the
// word that carries line end is followed by one status word (last = 1).
// A word is taken every cycle unless o_in_stall is high: it is registered,
// processed by the trim and split logic and written into a four-entry
// result queue. Only a line-end word yields two results, so the output side
// sets the rate: one result per cycle while i_out_stall is low.
// On a nonzero status, discard the line's tokens downstream.
module command_line_tokenizer_top
    import cltok_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire logic [7:0]       i_in_char,
    input  wire logic             i_line_end,
    input  wire logic             i_line_empty,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output logic                  o_char_valid,
    output logic [7:0]            o_out_char,
    output logic                  o_token_start,
    output logic                  o_is_status,
    output logic [2:0]            o_status_code,
    output logic [3:0]            o_open_mask,
    output logic [CNT_W-1:0]      o_token_count,
    output logic                  o_last
);

    logic       r_vld;
    logic [7:0] r_char;
    logic       r_end, r_empty;
    logic       step, room, load;
    t_trim      trim;
    t_step_res  res;
    t_result    head;

    assign step       = r_vld && room;
    assign o_in_stall = r_vld && !room;
    assign load       = i_in_valid && !o_in_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (!r_vld || step) begin
            r_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_char  <= i_in_char;
            r_end   <= i_line_end;
            r_empty <= i_line_empty;
        end
    end

    cltok_trim u_trim (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_char  (r_char),
        .i_end   (r_end),
        .i_empty (r_empty),
        .o_trim  (trim)
    );

    cltok_split u_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_char  (r_char),
        .i_end   (r_end),
        .i_trim  (trim),
        .o_res   (res)
    );

    cltok_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (step),
        .i_res   (res),
        .o_room  (room),
        .o_valid (o_out_valid),
        .i_pop   (!i_out_stall),
        .o_head  (head)
    );

    assign o_char_valid  = head.char_valid;
    assign o_out_char    = head.out_char;
    assign o_token_start = head.token_start;
    assign o_is_status   = head.is_status;
    assign o_status_code = head.status_code;
    assign o_open_mask   = head.open_mask;
    assign o_token_count = head.token_count;
    assign o_last        = head.last;

endmodule

`default_nettype wire

@@ rtl/core/cltok_trim.sv @@
// Comment and escape stage of the command line tokenizer.
`default_nettype none

module cltok_trim
    import cltok_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic [7:0] i_char,
    input  wire logic       i_end,
    input  wire logic       i_empty,
    output t_trim           o_trim
);

    logic r_in_comment, r_escape, r_trim_pipe;
    logic n_in_comment, n_escape, n_trim_pipe;
    logic keep;

    // Decide whether the byte survives comment removal
    always_comb begin
        n_in_comment = r_in_comment;
        n_escape     = r_escape;
        n_trim_pipe  = r_trim_pipe;
        keep         = 1'b1;
        if (i_empty) begin
            keep = 1'b0;
        end else if (r_in_comment) begin
            if (i_char == CH_NEWLINE) begin
                n_in_comment = 1'b0;
            end else begin
                keep = 1'b0;
            end
        end else if (r_escape) begin
            n_escape = 1'b0;
        end else if (i_char == CH_BSLASH) begin
            n_escape = 1'b1;
        end else if ((i_char == CH_HASH) && !r_trim_pipe) begin
            n_in_comment = 1'b1;
            keep         = 1'b0;
        end else if (i_char == CH_PIPE) begin
            n_trim_pipe = !r_trim_pipe;
        end
    end

    assign o_trim.keep      = keep;
    assign o_trim.trim_pipe = n_trim_pipe;

    // Advance on each step, clear at line end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_end)) begin
            r_in_comment <= 1'b0;
            r_escape     <= 1'b0;
            r_trim_pipe  <= 1'b0;
        end else if (i_step) begin
            r_in_comment <= n_in_comment;
            r_escape     <= n_escape;
            r_trim_pipe  <= n_trim_pipe;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/cltok_split.sv @@
// Token splitter and line status of the command line tokenizer.
`default_nettype none

module cltok_split
    import cltok_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic [7:0] i_char,
    input  wire logic       i_end,
    input  wire t_trim      i_trim,
    output t_step_res       o_res
);

    logic             r_inside, r_quote, r_pipe;
    logic [CNT_W-1:0] r_brace, r_paren, r_tokens;
    logic [1:0]       r_err;
    logic             n_inside, n_quote, n_pipe;
    logic [CNT_W-1:0] n_brace, n_paren, n_tokens;
    logic [1:0]       n_err;
    logic             emit, start, nested, ws;
    logic [3:0]       mask;

    // Track nesting and token boundaries for a kept byte
    always_comb begin
        n_inside = r_inside;
        n_quote  = r_quote;
        n_pipe   = r_pipe;
        n_brace  = r_brace;
        n_paren  = r_paren;
        n_tokens = r_tokens;
        n_err    = r_err;
        emit     = 1'b0;
        start    = 1'b0;
        ws       = is_ws(i_char);
        nested   = r_quote || r_pipe || (r_brace != '0) || (r_paren != '0);
        if (i_trim.keep && (r_err == ERR_NONE)) begin
            emit = 1'b1;
            if (!r_inside) begin
                if (ws) begin
                    emit = 1'b0;
                end else begin
                    n_inside = 1'b1;
                    start    = 1'b1;
                    if (r_tokens != CNT_MAX) n_tokens = r_tokens + 1'b1;
                end
            end else if (ws && !nested) begin
                n_inside = 1'b0;
                emit     = 1'b0;
            end
            if (emit) begin
                priority if (i_char == CH_QUOTE) begin
                    n_quote = !r_quote;
                end else if (i_char == CH_PIPE) begin
                    n_pipe = !r_pipe;
                end else if (i_char == CH_LBRACE) begin
                    if (r_brace != CNT_MAX) n_brace = r_brace + 1'b1;
                end else if (i_char == CH_RBRACE) begin
                    if (r_brace == '0) begin
                        n_err = ERR_BRACE;
                        emit  = 1'b0;
                    end else begin
                        n_brace = r_brace - 1'b1;
                    end
                end else if (i_char == CH_LPAREN) begin
                    if (r_paren != CNT_MAX) n_paren = r_paren + 1'b1;
                end else if (i_char == CH_RPAREN) begin
                    if (r_paren == '0) begin
                        n_err = ERR_PAREN;
                        emit  = 1'b0;
                    end else begin
                        n_paren = r_paren - 1'b1;
                    end
                end else begin
                    n_quote = r_quote;
                end
            end
        end
    end

    // Build the byte word and the status word
    always_comb begin
        mask           = '0;
        mask[OM_QUOTE] = n_quote;
        mask[OM_BRACE] = (n_brace != '0);
        mask[OM_PAREN] = (n_paren != '0);
        mask[OM_PIPE]  = n_pipe;

        o_res                      = '0;
        o_res.byte_valid           = emit;
        o_res.byte_res.char_valid  = 1'b1;
        o_res.byte_res.out_char    = i_char;
        o_res.byte_res.token_start = start;

        o_res.stat_valid          = i_end;
        o_res.stat_res.is_status  = 1'b1;
        o_res.stat_res.last       = 1'b1;
        priority if (i_trim.trim_pipe) begin
            o_res.stat_res.status_code = ST_TRIM_PIPE;
        end else if (n_err != ERR_NONE) begin
            o_res.stat_res.status_code = {1'b0, n_err};
        end else if (mask != '0) begin
            o_res.stat_res.status_code = ST_UNCLOSED;
            o_res.stat_res.open_mask   = mask;
        end else begin
            o_res.stat_res.status_code = ST_OK;
            o_res.stat_res.token_count = n_tokens;
        end
    end

    // Hold splitter state, clear at line end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_end)) begin
            r_inside <= 1'b0;
            r_quote  <= 1'b0;
            r_pipe   <= 1'b0;
            r_brace  <= '0;
            r_paren  <= '0;
            r_tokens <= '0;
            r_err    <= ERR_NONE;
        end else if (i_step) begin
            r_inside <= n_inside;
            r_quote  <= n_quote;
            r_pipe   <= n_pipe;
            r_brace  <= n_brace;
            r_paren  <= n_paren;
            r_tokens <= n_tokens;
            r_err    <= n_err;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/cltok_outq.sv @@
// Four-entry result queue taking up to two words per cycle while o_room is high.
`default_nettype none

module cltok_outq
    import cltok_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire t_step_res i_res,
    output logic           o_room,
    output logic           o_valid,
    input  wire logic      i_pop,
    output t_result        o_head
);

    t_result    r_mem [4];
    logic [1:0] r_wr, r_rd;
    logic [2:0] r_cnt;
    logic [1:0] wr2;
    logic [1:0] n_push;
    logic       pop;

    assign o_valid = (r_cnt != 3'd0);
    assign o_room  = (r_cnt <= 3'd2);
    assign o_head  = r_mem[r_rd];
    assign pop     = i_pop && o_valid;
    assign wr2     = r_wr + {1'b0, i_res.byte_valid};
    assign n_push  = i_push ? ({1'b0, i_res.byte_valid} + {1'b0, i_res.stat_valid}) : 2'd0;

    // Write the byte word, then the status word behind it
    always_ff @(posedge i_clk) begin
        if (i_push && i_res.byte_valid) r_mem[r_wr] <= i_res.byte_res;
        if (i_push && i_res.stat_valid) r_mem[wr2] <= i_res.stat_res;
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + n_push;
            r_rd  <= r_rd + {1'b0, pop};
            r_cnt <= r_cnt + {1'b0, n_push} - {2'b0, pop};
        end
    end

endmodule

`default_nettype wire
